### rtl/fpbm_pkg.sv
// ----------------------------------------------------------------------------
// fpbm_pkg
// shared types, constants and position tables of the pressure balance monitor
// ----------------------------------------------------------------------------
package fpbm_pkg;
	localparam int SensorCount   = 8;
	localparam int SampleBitsDef = 10;
	localparam int FracBitsDef   = 6;
	localparam int CentreFrac    = 7;

	localparam logic [2:0] RegPressureGain = 3'd0;
	localparam logic [2:0] RegContactOn    = 3'd1;
	localparam logic [2:0] RegContactOff   = 3'd2;
	localparam logic [2:0] RegCentreGain   = 3'd3;
	localparam logic [2:0] RegFlatLevel    = 3'd4;
	localparam logic [2:0] RegBalanceLimit = 3'd5;
	localparam logic [2:0] RegMinLoad      = 3'd6;

	typedef struct packed {
		logic [8:0] pressure_gain;
		logic [9:0] contact_on_level;
		logic [9:0] contact_off_level;
		logic [8:0] centre_gain;
		logic [9:0] flat_level;
		logic [6:0] balance_limit;
		logic [9:0] min_load_level;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic signed [47:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [47:0] quo;
	} div_rsp_t;

	function automatic logic signed [7:0] pos_x(input logic [2:0] i);
		logic signed [7:0] r;
		unique case (i)
			3'd0: r = -8'sd25;
			3'd1: r = 8'sd25;
			3'd2: r = -8'sd15;
			3'd3: r = 8'sd15;
			3'd4: r = -8'sd20;
			3'd5: r = 8'sd20;
			3'd6: r = -8'sd10;
			default: r = 8'sd10;
		endcase
		return r;
	endfunction

	function automatic logic signed [7:0] pos_y(input logic [2:0] i);
		logic signed [7:0] r;
		unique case (i)
			3'd0, 3'd1: r = -8'sd80;
			3'd2, 3'd3: r = -8'sd40;
			3'd4, 3'd5: r = 8'sd0;
			default: r = 8'sd40;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] sat_gain(input logic [8:0] v);
		return (v > 9'd256) ? 9'd256 : v;
	endfunction
endpackage

### rtl/fpbm_div.sv
// ----------------------------------------------------------------------------
// fpbm_div
// radix-2 restoring divider, signed numerator, quotient rounded half away
// ----------------------------------------------------------------------------
module fpbm_div
	import fpbm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int NB = 48;

	logic [NB-1:0] mag_q;
	logic [NB-1:0] quo_q;
	logic [NB:0]   rem_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [NB:0]   rem_sh;
	logic [NB:0]   rem_sub;
	logic [NB-1:0] q_fin;

	assign rem_sh  = {rem_q[NB-1:0], mag_q[NB-1]};
	assign rem_sub = rem_sh - {{(NB-31){1'b0}}, den_q};
	// remainder at end: round up when 2*rem >= den
	assign q_fin = quo_q + {{(NB-1){1'b0}}, ({rem_q[NB-1:0], 1'b0} >= {{(NB-31){1'b0}}, den_q})};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NB);
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[NB-1];
			mag_q <= req.num[NB-1] ? NB'(-req.num) : NB'(req.num);
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && cnt_q != 6'd0) begin
			mag_q <= {mag_q[NB-2:0], 1'b0};
			if (!rem_sub[NB]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end else if (busy_q) begin
			quo_q <= neg_q ? NB'(-q_fin) : q_fin;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

### rtl/fpbm_cfg.sv
// ----------------------------------------------------------------------------
// fpbm_cfg
// configuration register file
// ----------------------------------------------------------------------------
module fpbm_cfg
	import fpbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [2:0]  idx,
	input  logic [15:0] data,
	output cfg_t        cfg
);
	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{9'd51, 10'd153, 10'd51, 9'd77, 10'd205, 7'd30, 10'd102};
		end else if (we) begin
			unique case (idx)
				RegPressureGain: cfg_q.pressure_gain     <= sat_gain(data[8:0]);
				RegContactOn:    cfg_q.contact_on_level  <= data[9:0];
				RegContactOff:   cfg_q.contact_off_level <= data[9:0];
				RegCentreGain:   cfg_q.centre_gain       <= sat_gain(data[8:0]);
				RegFlatLevel:    cfg_q.flat_level        <= data[9:0];
				RegBalanceLimit: cfg_q.balance_limit     <= data[6:0];
				RegMinLoad:      cfg_q.min_load_level    <= data[9:0];
				default: ;
			endcase
		end
	end
	assign cfg = cfg_q;
endmodule

### rtl/foot_pressure_balance_monitor_core.sv
// ----------------------------------------------------------------------------
// foot_pressure_balance_monitor_core
// eight-sensor foot pressure smoothing, contact, centre and balance monitor
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready) takes one scan of eight raw counts per beat
//   out channel (out_valid/out_ready) gives one result beat per scan
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes registers
//   0..6; unknown indexes are ignored; cfg_ready is always high
// sequence: eight sensor steps on one shared multiplier, a sums step, then
//   four divides (centre x, centre y, side and length balance) on one
//   48-step restoring divider, with a centre smoothing step after the
//   centre divides; when the summed load is 10 counts or less the centre
//   divides and the centre smoothing are skipped
// throughput: one scan at a time; in_ready is low from accept until the
//   result beat is taken
// reset: smoothed levels, contact flags and centre state clear to zero,
//   registers load their defaults
// stall: result fields come from state registers held until out_ready
// ----------------------------------------------------------------------------
module foot_pressure_balance_monitor_core
	import fpbm_pkg::*;
#(
	parameter int SAMPLE_BITS   = SampleBitsDef,
	parameter int FRACTION_BITS = FracBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [SAMPLE_BITS-1:0] heel_left_raw,
	input  logic [SAMPLE_BITS-1:0] heel_right_raw,
	input  logic [SAMPLE_BITS-1:0] mid_left_raw,
	input  logic [SAMPLE_BITS-1:0] mid_right_raw,
	input  logic [SAMPLE_BITS-1:0] ball_left_raw,
	input  logic [SAMPLE_BITS-1:0] ball_right_raw,
	input  logic [SAMPLE_BITS-1:0] big_toe_raw,
	input  logic [SAMPLE_BITS-1:0] small_toes_raw,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] contact_mask,
	output logic foot_contact,
	output logic [9:0] mean_load,
	output logic signed [5:0] centre_x_mm,
	output logic signed [7:0] centre_y_mm,
	output logic [1:0] loading_class,
	output logic stable_flag,
	output logic signed [7:0] balance_side,
	output logic signed [7:0] balance_length
);
	localparam int LW = SAMPLE_BITS + FRACTION_BITS;  // smoothed level width
	localparam int SW = LW + 3;                        // sum of eight
	localparam int KC = ((4 * ((1 << SAMPLE_BITS) - 1) << FRACTION_BITS) + 50) / 100;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SMTH = 3'd1;
	localparam logic [2:0] ST_SUMS = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_CACC = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	cfg_t cfg;
	fpbm_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .we(cfg_valid), .idx(cfg_index),
		.data(cfg_data), .cfg(cfg)
	);
	assign cfg_ready = 1'b1;

	logic [2:0] state_q;
	logic [2:0] idx_q;
	logic [1:0] dsel_q;
	logic       dstart_q;
	logic [SAMPLE_BITS-1:0] raw_q [SensorCount];
	logic [LW-1:0] lvl_q [SensorCount];
	logic [SensorCount-1:0] flag_q;
	logic signed [13:0] cx_q;
	logic signed [14:0] cy_q;
	logic [SW-1:0] tot_q, heel_q, fore_q, left_q, right_q, mid_q;
	logic signed [SW+8:0] wx_q, wy_q;
	logic signed [47:0] nx_q, ny_q;
	logic signed [8:0] bs_q, bl_q;
	logic side_ok_q, len_ok_q;

	// shared datapath multiplier: one smoothing step per cycle
	logic [LW-1:0]  cur_lvl;
	logic [LW+9:0]  mix;
	logic [LW-1:0]  new_lvl;
	logic [8:0]     pg;
	assign pg      = cfg.pressure_gain;
	assign cur_lvl = lvl_q[idx_q];
	assign mix = (LW+10)'(pg) * (LW+10)'({raw_q[idx_q], FRACTION_BITS'(0)})
	           + (LW+10)'(9'd256 - pg) * (LW+10)'(cur_lvl) + (LW+10)'(128);
	assign new_lvl = LW'(mix >> 8);

	// divider shared over centre and balance ratios
	div_req_t dreq;
	div_rsp_t drsp;
	fpbm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic signed [SW+1:0] sdiff, ldiff;
	logic [SW+1:0] sden, lden;
	assign sdiff = $signed({2'b0, left_q}) - $signed({2'b0, right_q});
	assign sden  = {2'b0, left_q} + {2'b0, right_q} + (SW+2)'(KC);
	assign ldiff = $signed({2'b0, fore_q}) - $signed({1'b0, heel_q, 1'b0});
	assign lden  = {2'b0, fore_q} + {1'b0, heel_q, 1'b0} + (SW+2)'(KC);

	always_comb begin
		dreq.start = dstart_q;
		unique case (dsel_q)
			2'd0: begin dreq.num = 48'(wx_q) <<< CentreFrac; dreq.den = 32'(tot_q); end
			2'd1: begin dreq.num = 48'(wy_q) <<< CentreFrac; dreq.den = 32'(tot_q); end
			2'd2: begin dreq.num = 48'(sdiff) * 48'sd100;    dreq.den = 32'(sden);  end
			default: begin dreq.num = 48'(ldiff) * 48'sd100; dreq.den = 32'(lden); end
		endcase
	end

	// centre smoothing, rounded half away from zero
	function automatic logic signed [31:0] csmooth(input logic signed [31:0] acc,
		input logic signed [31:0] fresh, input logic [8:0] g);
		logic signed [47:0] t;
		logic [47:0] m;
		logic [47:0] q;
		t = 48'(signed'({1'b0, g})) * 48'(fresh) + 48'(signed'({1'b0, 9'd256 - g})) * 48'(acc);
		m = t[47] ? 48'(-t) : 48'(t);
		q = (m + 48'd128) >> 8;
		return t[47] ? -32'(q) : 32'(q);
	endfunction

	logic signed [8:0] quo_clamp;
	logic [55:0] lhs_mag, rhs_lim;
	always_comb begin
		if (drsp.quo > 48'sd100)       quo_clamp = 9'sd100;
		else if (drsp.quo < -48'sd100) quo_clamp = -9'sd100;
		else                           quo_clamp = 9'(drsp.quo);
		lhs_mag = (dsel_q == 2'd2) ? 56'(sdiff[SW+1] ? -sdiff : sdiff) * 56'd100
		                           : 56'(ldiff[SW+1] ? -ldiff : ldiff) * 56'd100;
		rhs_lim = (dsel_q == 2'd2) ? 56'(cfg.balance_limit) * 56'(sden)
		                           : 56'(cfg.balance_limit) * 56'(lden);
	end

	logic in_acc, out_acc;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			dsel_q   <= '0;
			dstart_q <= 1'b0;
			flag_q   <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < SensorCount; i++) lvl_q[i] <= '0;
		end else begin
			dstart_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					idx_q   <= '0;
					state_q <= ST_SMTH;
				end
				ST_SMTH: begin
					// one sensor per cycle through the shared multiplier
					lvl_q[idx_q] <= new_lvl;
					if (!flag_q[idx_q] && new_lvl > {cfg.contact_on_level, FRACTION_BITS'(0)})
						flag_q[idx_q] <= 1'b1;
					else if (flag_q[idx_q] &&
					         new_lvl < {cfg.contact_off_level, FRACTION_BITS'(0)})
						flag_q[idx_q] <= 1'b0;
					if (idx_q == 3'd7) state_q <= ST_SUMS;
					idx_q <= idx_q + 3'd1;
				end
				ST_SUMS: begin
					dsel_q   <= (tot_q > SW'(10 << FRACTION_BITS)) ? 2'd0 : 2'd2;
					dstart_q <= 1'b1;
					state_q  <= ST_DIV;
				end
				ST_DIV: if (drsp.done) begin
					unique case (dsel_q)
						2'd0: begin nx_q <= drsp.quo; dsel_q <= 2'd1; dstart_q <= 1'b1; end
						2'd1: begin ny_q <= drsp.quo; state_q <= ST_CACC; end
						2'd2: begin
							bs_q <= quo_clamp; side_ok_q <= lhs_mag < rhs_lim;
							dsel_q <= 2'd3; dstart_q <= 1'b1;
						end
						default: begin
							bl_q <= quo_clamp; len_ok_q <= lhs_mag < rhs_lim;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_CACC: begin
					cx_q <= 14'(csmooth(32'(cx_q), 32'(nx_q), cfg.centre_gain));
					cy_q <= 15'(csmooth(32'(cy_q), 32'(ny_q), cfg.centre_gain));
					dsel_q   <= 2'd2;
					dstart_q <= 1'b1;
					state_q  <= ST_DIV;
				end
				ST_OUT: begin
					if (!out_valid) out_valid <= 1'b1;
					else if (out_acc) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// raw capture and sums of the fresh levels
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q[0] <= heel_left_raw;  raw_q[1] <= heel_right_raw;
			raw_q[2] <= mid_left_raw;   raw_q[3] <= mid_right_raw;
			raw_q[4] <= ball_left_raw;  raw_q[5] <= ball_right_raw;
			raw_q[6] <= big_toe_raw;    raw_q[7] <= small_toes_raw;
			tot_q <= '0; heel_q <= '0; fore_q <= '0; left_q <= '0;
			right_q <= '0; mid_q <= '0; wx_q <= '0; wy_q <= '0;
		end else if (state_q == ST_SMTH) begin
			tot_q <= tot_q + SW'(new_lvl);
			wx_q  <= wx_q + (SW+9)'($signed({1'b0, new_lvl})) * (SW+9)'(pos_x(idx_q));
			wy_q  <= wy_q + (SW+9)'($signed({1'b0, new_lvl})) * (SW+9)'(pos_y(idx_q));
			if (idx_q[0]) right_q <= right_q + SW'(new_lvl);
			else          left_q  <= left_q + SW'(new_lvl);
			if (idx_q[2:1] == 2'd0) heel_q <= heel_q + SW'(new_lvl);
			if (idx_q[2:1] == 2'd1) mid_q  <= mid_q + SW'(new_lvl);
			if (idx_q[2])           fore_q <= fore_q + SW'(new_lvl);
		end
	end

	// output field derivation from held state
	logic signed [5:0] cxr;
	logic signed [7:0] cyr;
	logic [1:0] cls;
	always_comb begin
		cxr = cx_q[13] ? -6'(($unsigned(-cx_q) + 14'd64) >> 7) : 6'((cx_q + 14'sd64) >>> 7);
		cyr = cy_q[14] ? -8'(($unsigned(-cy_q) + 15'd64) >> 7) : 8'((cy_q + 15'sd64) >>> 7);
		if ((SW+3)'(heel_q) * 4 > (SW+3)'(fore_q) * 3)   cls = 2'd0;
		else if ((SW+3)'(fore_q) > (SW+3)'(heel_q) * 3) cls = 2'd1;
		else if ((SW+3)'(mid_q) > (SW+3)'({cfg.flat_level, FRACTION_BITS'(0), 1'b0}))
			cls = 2'd2;
		else cls = 2'd3;
	end

	assign contact_mask   = flag_q;
	assign foot_contact   = |flag_q;
	assign mean_load      = 10'(tot_q >> (3 + FRACTION_BITS));
	assign centre_x_mm    = cxr;
	assign centre_y_mm    = cyr;
	assign loading_class  = cls;
	assign stable_flag    = side_ok_q && len_ok_q &&
	                        (tot_q > SW'({cfg.min_load_level, FRACTION_BITS'(0), 3'b0}));
	assign balance_side   = 8'(bs_q);
	assign balance_length = 8'(bl_q);
endmodule

### rtl/fpbm_checker.sv
// ----------------------------------------------------------------------------
// fpbm_checker
// port-level checks of the pressure balance monitor
// ----------------------------------------------------------------------------
module fpbm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] contact_mask,
	input logic foot_contact,
	input logic signed [7:0] balance_side
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready)) else $error("result and ready together");
	a_gc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> foot_contact == (contact_mask != 8'd0)) else $error("ground");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(balance_side)) else $error("hold");
endmodule

bind foot_pressure_balance_monitor_core fpbm_checker u_fpbm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .contact_mask(contact_mask),
	.foot_contact(foot_contact), .balance_side(balance_side)
);
